FILE: src/rect_to_polar_convert_defines.svh
// Assertion macros shared by the rectangular-to-polar converter modules.
`ifndef RECT_TO_POLAR_CONVERT_DEFINES_SVH
`define RECT_TO_POLAR_CONVERT_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RTP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RTP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/rtp_pkg.sv
// Package with the constants, angle table and shared types of the converter.
package rtp_pkg;

   localparam int COORD_WIDTH_DEF    = 16;
   localparam int ROTATION_STEPS_DEF = 16;
   localparam int GUARD_BITS         = 16;
   localparam int TABLE_LEN          = 32;
   localparam int ACC_WIDTH          = 32;
   localparam int MAG_WIDTH          = 16;
   localparam int ANGLE_WIDTH        = 17;
   localparam int ANGLE_SHIFT        = 16;

   localparam logic [ANGLE_WIDTH-1:0] HALF_PI_UNITS       = 17'd16384;
   localparam logic [ANGLE_WIDTH-1:0] PI_UNITS            = 17'd32768;
   localparam logic [ANGLE_WIDTH-1:0] THREE_HALF_PI_UNITS = 17'd49152;
   localparam logic [ACC_WIDTH:0]     ROUND_HALF          = 33'd32768;

   localparam int ANGLE_MIN = -32768;
   localparam int ANGLE_MAX = 49152;

   // Entry i is round(atan(2^-i) / pi * 2^31).
   localparam logic [ACC_WIDTH-1:0] ROT_ANGLE [TABLE_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81,
      32'd41,        32'd20,        32'd10,        32'd5,
      32'd3,         32'd1,         32'd1,         32'd0
   };

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } rtp_flags_type;

endpackage

FILE: src/rtp_req_if.sv
// Request channel carrying one rectangular point.
interface rtp_req_if #(
   parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x_coord;
   logic signed [COORD_WIDTH-1:0] y_coord;

   modport source (output valid, output x_coord, output y_coord, input ready);
   modport sink (input valid, input x_coord, input y_coord, output ready);
endinterface

FILE: src/rtp_rsp_if.sv
// Result channel carrying one magnitude and angle pair.
interface rtp_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic        [rtp_pkg::MAG_WIDTH-1:0]   magnitude;
   logic signed [rtp_pkg::ANGLE_WIDTH-1:0] angle;

   modport source (output valid, output magnitude, output angle, input ready);
   modport sink (input valid, input magnitude, input angle, output ready);
endinterface

FILE: src/rtp_front.sv
// Front end: absolute values, squares and the start of both iterations.
module rtp_front #(
   parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                              clock,
   input  logic                                              reset,
   rtp_req_if.sink                                           req,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic        [2*COORD_WIDTH-1:0]                   out_rad,
   output logic signed [COORD_WIDTH+rtp_pkg::GUARD_BITS+2:0] out_a,
   output logic signed [COORD_WIDTH+rtp_pkg::GUARD_BITS+2:0] out_b,
   output rtp_pkg::rtp_flags_type                            out_flags
);
   import rtp_pkg::*;

   localparam int W  = COORD_WIDTH;
   localparam int RW = 2 * COORD_WIDTH;

   logic          [W-1:0]  x_bits;
   logic          [W-1:0]  y_bits;
   logic          [W-1:0]  ax_in;
   logic          [W-1:0]  ay_in;
   rtp_flags_type          flags_in;

   logic                   valid1_ff;
   logic          [W-1:0]  ax1_ff;
   logic          [W-1:0]  ay1_ff;
   rtp_flags_type          flags1_ff;
   logic                   load1;

   logic                   valid2_ff;
   logic          [RW-1:0] sqx2_ff;
   logic          [RW-1:0] sqy2_ff;
   logic          [RW-1:0] sqx_in;
   logic          [RW-1:0] sqy_in;
   logic          [W-1:0]  ax2_ff;
   logic          [W-1:0]  ay2_ff;
   rtp_flags_type          flags2_ff;
   logic                   load2;

   logic                   valid3_ff;
   logic          [RW-1:0] rad3_ff;
   logic          [W-1:0]  ax3_ff;
   logic          [W-1:0]  ay3_ff;
   rtp_flags_type          flags3_ff;
   logic                   load3;

   assign x_bits = req.x_coord;
   assign y_bits = req.y_coord;

   // The most negative code negates to its own pattern, which read unsigned is correct.
   assign ax_in = x_bits[W-1] ? (~x_bits) + {{(W-1){1'b0}}, 1'b1} : x_bits;
   assign ay_in = y_bits[W-1] ? (~y_bits) + {{(W-1){1'b0}}, 1'b1} : y_bits;

   assign flags_in.x_neg  = x_bits[W-1];
   assign flags_in.y_neg  = y_bits[W-1];
   assign flags_in.x_zero = (x_bits == '0);
   assign flags_in.y_zero = (y_bits == '0);

   assign sqx_in = {{W{1'b0}}, ax1_ff} * {{W{1'b0}}, ax1_ff};
   assign sqy_in = {{W{1'b0}}, ay1_ff} * {{W{1'b0}}, ay1_ff};

   assign load3     = !valid3_ff || out_ready;
   assign load2     = !valid2_ff || load3;
   assign load1     = !valid1_ff || load2;
   assign req.ready = load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else begin
         if (load1) valid1_ff <= req.valid;
         if (load2) valid2_ff <= valid1_ff;
         if (load3) valid3_ff <= valid2_ff;
      end
      if (load1) begin
         ax1_ff    <= ax_in;
         ay1_ff    <= ay_in;
         flags1_ff <= flags_in;
      end
      if (load2) begin
         sqx2_ff   <= sqx_in;
         sqy2_ff   <= sqy_in;
         ax2_ff    <= ax1_ff;
         ay2_ff    <= ay1_ff;
         flags2_ff <= flags1_ff;
      end
      if (load3) begin
         // Both squares are at most 2^(2W-2), so the sum cannot overflow.
         rad3_ff   <= sqx2_ff + sqy2_ff;
         ax3_ff    <= ax2_ff;
         ay3_ff    <= ay2_ff;
         flags3_ff <= flags2_ff;
      end
   end

   assign out_valid = valid3_ff;
   assign out_rad   = rad3_ff;
   assign out_a     = {3'b000, ax3_ff, {GUARD_BITS{1'b0}}};
   assign out_b     = {3'b000, ay3_ff, {GUARD_BITS{1'b0}}};
   assign out_flags = flags3_ff;

endmodule

FILE: src/rtp_stage.sv
// One pipeline stage: one square-root digit and one vectoring rotation, each passed through past its step count.
`include "rect_to_polar_convert_defines.svh"

module rtp_stage #(
   parameter int COORD_WIDTH    = rtp_pkg::COORD_WIDTH_DEF,
   parameter int ROTATION_STEPS = rtp_pkg::ROTATION_STEPS_DEF,
   parameter int STEP           = 0
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              in_valid,
   output logic                                              in_ready,
   input  logic        [2*COORD_WIDTH-1:0]                   in_rem,
   input  logic        [2*COORD_WIDTH-1:0]                   in_root,
   input  logic signed [COORD_WIDTH+rtp_pkg::GUARD_BITS+2:0] in_a,
   input  logic signed [COORD_WIDTH+rtp_pkg::GUARD_BITS+2:0] in_b,
   input  logic signed [rtp_pkg::ACC_WIDTH-1:0]              in_acc,
   input  rtp_pkg::rtp_flags_type                            in_flags,
   output logic                                              out_valid,
   input  logic                                              out_ready,
   output logic        [2*COORD_WIDTH-1:0]                   out_rem,
   output logic        [2*COORD_WIDTH-1:0]                   out_root,
   output logic signed [COORD_WIDTH+rtp_pkg::GUARD_BITS+2:0] out_a,
   output logic signed [COORD_WIDTH+rtp_pkg::GUARD_BITS+2:0] out_b,
   output logic signed [rtp_pkg::ACC_WIDTH-1:0]              out_acc,
   output rtp_pkg::rtp_flags_type                            out_flags
);
   import rtp_pkg::*;

   localparam int RW = 2 * COORD_WIDTH;
   localparam int CW = COORD_WIDTH + GUARD_BITS + 3;

   logic                        valid_ff;
   logic        [RW-1:0]        rem_ff;
   logic        [RW-1:0]        root_ff;
   logic signed [CW-1:0]        a_ff;
   logic signed [CW-1:0]        b_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff;
   rtp_flags_type               flags_ff;

   logic        [RW-1:0]        rem_in;
   logic        [RW-1:0]        root_in;
   logic signed [CW-1:0]        a_in;
   logic signed [CW-1:0]        b_in;
   logic signed [ACC_WIDTH-1:0] acc_in;

   generate
      if (STEP < COORD_WIDTH) begin : g_sqrt
         localparam logic [RW-1:0] SQ_BIT = RW'(1) << (2 * (COORD_WIDTH - 1 - STEP));
         logic [RW:0] trial;
         logic        take;
         assign trial   = {1'b0, in_root} + {1'b0, SQ_BIT};
         assign take    = ({1'b0, in_rem} >= trial);
         assign rem_in  = take ? (in_rem - trial[RW-1:0]) : in_rem;
         assign root_in = take ? ((in_root >> 1) + SQ_BIT) : (in_root >> 1);
      end else begin : g_sqrt_done
         assign rem_in  = in_rem;
         assign root_in = in_root;
      end

      if (STEP < ROTATION_STEPS) begin : g_rotate
         localparam logic signed [ACC_WIDTH-1:0] STEP_ANGLE = ROT_ANGLE[STEP];
         logic signed [CW-1:0] sa;
         logic signed [CW-1:0] sb;
         logic                 b_pos;
         assign sa     = in_a >>> STEP;
         assign sb     = in_b >>> STEP;
         // Rotate towards the x axis: clockwise while b is zero or above.
         assign b_pos  = !in_b[CW-1];
         assign a_in   = b_pos ? (in_a + sb) : (in_a - sb);
         assign b_in   = b_pos ? (in_b - sa) : (in_b + sa);
         assign acc_in = b_pos ? (in_acc + STEP_ANGLE) : (in_acc - STEP_ANGLE);
      end else begin : g_rotate_done
         assign a_in   = in_a;
         assign b_in   = in_b;
         assign acc_in = in_acc;
      end
   endgenerate

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         rem_ff   <= rem_in;
         root_ff  <= root_in;
         a_ff     <= a_in;
         b_ff     <= b_in;
         acc_ff   <= acc_in;
         flags_ff <= in_flags;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_acc   = acc_ff;
   assign out_flags = flags_ff;

   `RTP_ASSERT_NEXT(a_stage_hold, clock, reset, valid_ff && !out_ready, valid_ff && $stable(acc_ff) && $stable(root_ff) && $stable(flags_ff), "stalled stage changed its request")

endmodule

FILE: src/rtp_place.sv
// Output stage: angle rounding, quadrant placement and the result register.
`include "rect_to_polar_convert_defines.svh"

module rtp_place #(
   parameter int COORD_WIDTH = rtp_pkg::COORD_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   output logic                                 in_ready,
   input  logic        [2*COORD_WIDTH-1:0]      in_root,
   input  logic signed [rtp_pkg::ACC_WIDTH-1:0] in_acc,
   input  rtp_pkg::rtp_flags_type               in_flags,
   rtp_rsp_if.source                            rsp
);
   import rtp_pkg::*;

   logic                          valid_ff;
   logic        [MAG_WIDTH-1:0]   mag_ff;
   logic signed [ANGLE_WIDTH-1:0] angle_ff;

   logic        [ACC_WIDTH-1:0]   acc_pos;
   logic        [ACC_WIDTH:0]     rounded;
   logic        [ANGLE_WIDTH-1:0] theta_raw;
   logic        [ANGLE_WIDTH-1:0] theta;
   logic        [ANGLE_WIDTH-1:0] placed;
   logic        [ANGLE_WIDTH-1:0] angle_in;

   assign acc_pos   = in_acc[ACC_WIDTH-1] ? '0 : in_acc;
   assign rounded   = {1'b0, acc_pos} + ROUND_HALF;
   assign theta_raw = ANGLE_WIDTH'(rounded >> ANGLE_SHIFT);
   assign theta     = (theta_raw > HALF_PI_UNITS) ? HALF_PI_UNITS : theta_raw;
   assign placed    = in_flags.x_neg ? (PI_UNITS - theta) : theta;

   always_comb begin
      priority if (in_flags.x_zero) begin
         // The negative y axis reports three quarter turns rather than minus a quarter turn.
         if (in_flags.y_zero) begin
            angle_in = '0;
         end else if (in_flags.y_neg) begin
            angle_in = THREE_HALF_PI_UNITS;
         end else begin
            angle_in = HALF_PI_UNITS;
         end
      end else if (in_flags.y_zero) begin
         angle_in = in_flags.x_neg ? PI_UNITS : '0;
      end else begin
         angle_in = in_flags.y_neg ? (~placed) + {{(ANGLE_WIDTH-1){1'b0}}, 1'b1} : placed;
      end
   end

   assign in_ready = !valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         mag_ff   <= in_root[MAG_WIDTH-1:0];
         angle_ff <= angle_in;
      end
   end

   assign rsp.valid     = valid_ff;
   assign rsp.magnitude = mag_ff;
   assign rsp.angle     = angle_ff;

   `RTP_ASSERT_NEXT(a_origin_zero, clock, reset, in_valid && in_ready && in_flags.x_zero && in_flags.y_zero, rsp.valid && rsp.angle == '0 && rsp.magnitude == '0, "origin did not give a zero result")
   `RTP_ASSERT_NOW(a_angle_range, clock, reset, rsp.valid, rsp.angle >= ANGLE_MIN && rsp.angle <= ANGLE_MAX, "angle outside its range")

endmodule

FILE: src/rect_to_polar_convert.sv
// Requests pass the front end, the stage chain and the result register in turn, one per cycle
// unless the result side stalls; a square-root digit and a rotation share each stage.
// Every stage has its own valid bit and advances when empty or when its successor moves,
// so a stall at the result side fills bubbles first and drops nothing.
// Reset (synchronous, active high) clears only the valid bits; no state lives across requests.
module rect_to_polar_convert #(
   parameter int COORD_WIDTH    = rtp_pkg::COORD_WIDTH_DEF,
   parameter int ROTATION_STEPS = rtp_pkg::ROTATION_STEPS_DEF
) (
   input logic       clock,
   input logic       reset,
   rtp_req_if.sink   req_chan,
   rtp_rsp_if.source rsp_chan
);
   import rtp_pkg::*;

   localparam int RW     = 2 * COORD_WIDTH;
   localparam int CW     = COORD_WIDTH + GUARD_BITS + 3;
   localparam int STAGES = (COORD_WIDTH > ROTATION_STEPS) ? COORD_WIDTH : ROTATION_STEPS;

   logic                        valid_chain [STAGES+1];
   logic                        ready_chain [STAGES+1];
   logic        [RW-1:0]        root_chain  [STAGES+1];
   logic signed [ACC_WIDTH-1:0] acc_chain   [STAGES+1];
   rtp_flags_type               flags_chain [STAGES+1];
   logic        [RW-1:0]        rem_chain   [STAGES];
   logic signed [CW-1:0]        a_chain     [STAGES];
   logic signed [CW-1:0]        b_chain     [STAGES];

   rtp_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_rad   (rem_chain[0]),
      .out_a     (a_chain[0]),
      .out_b     (b_chain[0]),
      .out_flags (flags_chain[0])
   );

   assign root_chain[0] = '0;
   assign acc_chain[0]  = '0;

   generate
      for (genvar j = 0; j < STAGES; j++) begin : g_stage
         if (j < STAGES - 1) begin : g_mid
            rtp_stage #(
               .COORD_WIDTH    (COORD_WIDTH),
               .ROTATION_STEPS (ROTATION_STEPS),
               .STEP           (j)
            ) u_stage (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (valid_chain[j]),
               .in_ready  (ready_chain[j]),
               .in_rem    (rem_chain[j]),
               .in_root   (root_chain[j]),
               .in_a      (a_chain[j]),
               .in_b      (b_chain[j]),
               .in_acc    (acc_chain[j]),
               .in_flags  (flags_chain[j]),
               .out_valid (valid_chain[j+1]),
               .out_ready (ready_chain[j+1]),
               .out_rem   (rem_chain[j+1]),
               .out_root  (root_chain[j+1]),
               .out_a     (a_chain[j+1]),
               .out_b     (b_chain[j+1]),
               .out_acc   (acc_chain[j+1]),
               .out_flags (flags_chain[j+1])
            );
         end else begin : g_last
            // The last stage's remainder and vector pair are no longer needed.
            rtp_stage #(
               .COORD_WIDTH    (COORD_WIDTH),
               .ROTATION_STEPS (ROTATION_STEPS),
               .STEP           (j)
            ) u_stage (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (valid_chain[j]),
               .in_ready  (ready_chain[j]),
               .in_rem    (rem_chain[j]),
               .in_root   (root_chain[j]),
               .in_a      (a_chain[j]),
               .in_b      (b_chain[j]),
               .in_acc    (acc_chain[j]),
               .in_flags  (flags_chain[j]),
               .out_valid (valid_chain[j+1]),
               .out_ready (ready_chain[j+1]),
               .out_rem   (),
               .out_root  (root_chain[j+1]),
               .out_a     (),
               .out_b     (),
               .out_acc   (acc_chain[j+1]),
               .out_flags (flags_chain[j+1])
            );
         end
      end
   endgenerate

   rtp_place #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_place (
      .clock    (clock),
      .reset    (reset),
      .in_valid (valid_chain[STAGES]),
      .in_ready (ready_chain[STAGES]),
      .in_root  (root_chain[STAGES]),
      .in_acc   (acc_chain[STAGES]),
      .in_flags (flags_chain[STAGES]),
      .rsp      (rsp_chan)
   );

endmodule
